[design/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, codes and helpers of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int POOLS          = 8;
  localparam int WORDS_PER_POOL = 4;
  localparam int WORD_BITS      = 32;
  localparam int SLOTS          = WORDS_PER_POOL * WORD_BITS;

  // field widths are fixed by the interface
  localparam int POOL_W = 3;
  localparam int SLOT_W = 7;
  localparam int FREE_W = 11;
  localparam int CNT_W  = $clog2(POOLS + 1);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BAD_FREE  = 2'd2
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [POOL_W-1:0] rd_addr;
    logic              wr_en;
    logic [POOL_W-1:0] wr_addr;
    logic [SLOTS-1:0]  wr_data;
  } bsa_mem_req_t;

  // index of the lowest clear bit; only meaningful when one exists
  function automatic logic [SLOT_W-1:0] lowest_zero(input logic [SLOTS-1:0] map);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!map[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

[design/bsa_if.sv]
// ----------------------------------------------------------------------------
// bsa_if
// Request and response channels of the bitmap slot allocator.
// ----------------------------------------------------------------------------
interface bsa_req_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [POOL_W-1:0] pool_index;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, op, pool_index, slot_index, input ready);
  modport sink   (input valid, op, pool_index, slot_index, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic [POOL_W-1:0] pool_out;
  logic [SLOT_W-1:0] slot_out;
  logic [1:0]        status;
  logic [FREE_W-1:0] free_total;

  modport source (output valid, granted, pool_out, slot_out, status, free_total,
                  input ready);
  modport sink   (input valid, granted, pool_out, slot_out, status, free_total,
                  output ready);
endinterface

[design/bsa_bitmap_mem.sv]
// ----------------------------------------------------------------------------
// bsa_bitmap_mem
// Occupancy bitmaps, one row per pool; one write and one registered read port.
// ----------------------------------------------------------------------------
module bsa_bitmap_mem import bsa_pkg::*; (
  input  logic             clk,
  input  bsa_mem_req_t     mem_req,
  output logic [SLOTS-1:0] rd_data
);

  // rows are written on activation before any read, so no reset is needed
  logic [SLOTS-1:0] mem [POOLS];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) mem[mem_req.wr_addr] <= mem_req.wr_data;
    if (mem_req.rd_en) rd_data <= mem[mem_req.rd_addr];
  end

endmodule

[design/bsa_ctrl.sv]
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request decode, pool selection, bitmap read-modify-write and result register.
// ----------------------------------------------------------------------------
module bsa_ctrl import bsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bsa_req_if.sink          req,
  bsa_rsp_if.source        rsp,
  output bsa_mem_req_t     mem_req,
  input  logic [SLOTS-1:0] rd_data
);

  typedef enum logic [0:0] {S_IDLE, S_EXEC} state_t;
  typedef enum logic [2:0] {M_TAKE, M_ACTIVATE, M_FREE, M_BAD_FREE, M_EXHAUSTED} mode_t;

  state_t            state;
  mode_t             mode_q;
  logic [POOL_W-1:0] pool_q;
  logic [SLOT_W-1:0] slot_q;

  logic [CNT_W-1:0]  active_pools;
  logic [FREE_W-1:0] free_count;
  logic [POOL_W-1:0] cached_pool;
  logic              cache_valid;
  logic [POOLS-1:0]  pool_full;

  logic [POOLS-1:0]  active_mask;
  logic [POOLS-1:0]  open_mask;
  logic [POOL_W-1:0] first_open;
  logic              cache_ok;
  logic              accept;
  mode_t             mode_sel;
  logic [POOL_W-1:0] pool_sel;
  logic              drop_cache;

  logic              go;
  logic [SLOTS-1:0]  rd_map;
  logic [SLOT_W-1:0] take_idx;
  logic [SLOTS-1:0]  take_map;
  logic              take_full;
  logic              free_hit;
  logic [SLOTS-1:0]  free_map;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    for (int p = 0; p < POOLS; p++) begin
      active_mask[p] = (CNT_W'(p) < active_pools);
    end
    open_mask  = active_mask & ~pool_full;
    first_open = '0;
    for (int p = POOLS - 1; p >= 0; p--) begin
      if (open_mask[p]) first_open = POOL_W'(p);
    end
    cache_ok = cache_valid && (CNT_W'(cached_pool) < active_pools) && !pool_full[cached_pool];

    mode_sel   = M_EXHAUSTED;
    pool_sel   = '0;
    drop_cache = 1'b0;
    if (req.op == OP_FREE) begin
      pool_sel = req.pool_index;
      if ((CNT_W'(req.pool_index) < active_pools) &&
          ({1'b0, req.slot_index} < (SLOT_W + 1)'(SLOTS))) begin
        mode_sel = M_FREE;
      end else begin
        mode_sel = M_BAD_FREE;
      end
    end else if (cache_ok) begin
      mode_sel = M_TAKE;
      pool_sel = cached_pool;
    end else begin
      drop_cache = 1'b1;
      if (|open_mask) begin
        mode_sel = M_TAKE;
        pool_sel = first_open;
      end else if (active_pools < CNT_W'(POOLS)) begin
        mode_sel = M_ACTIVATE;
        pool_sel = active_pools[POOL_W-1:0];
      end
    end
  end

  // execute stage: bitmap row arrives from the memory this cycle
  always_comb begin
    go        = (state == S_EXEC) && (!rsp.valid || rsp.ready);
    rd_map    = (mode_q == M_ACTIVATE) ? '0 : rd_data;
    take_idx  = lowest_zero(rd_map);
    take_map  = rd_map | (SLOTS'(1) << take_idx);
    take_full = &take_map;
    free_hit  = rd_map[slot_q];
    free_map  = rd_map & ~(SLOTS'(1) << slot_q);

    mem_req.rd_en   = accept && (mode_sel == M_TAKE || mode_sel == M_FREE);
    mem_req.rd_addr = pool_sel;
    mem_req.wr_en   = go && (mode_q == M_TAKE || mode_q == M_ACTIVATE ||
                             (mode_q == M_FREE && free_hit));
    mem_req.wr_addr = pool_q;
    mem_req.wr_data = (mode_q == M_FREE) ? free_map : take_map;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_pools <= '0;
      free_count   <= '0;
      cached_pool  <= '0;
      cache_valid  <= 1'b0;
      pool_full    <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (go) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q <= mode_sel;
            pool_q <= pool_sel;
            slot_q <= req.slot_index;
            if (drop_cache) cache_valid <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            state <= S_IDLE;
            case (mode_q)
              M_TAKE, M_ACTIVATE: begin
                rsp.granted  <= 1'b1;
                rsp.pool_out <= pool_q;
                rsp.slot_out <= take_idx;
                rsp.status   <= STATUS_OK;
                pool_full[pool_q] <= take_full;
                if (mode_q == M_ACTIVATE) begin
                  active_pools   <= active_pools + CNT_W'(1);
                  free_count     <= free_count + FREE_W'(SLOTS - 1);
                  rsp.free_total <= free_count + FREE_W'(SLOTS - 1);
                  cached_pool    <= pool_q;
                  cache_valid    <= !take_full;
                end else begin
                  if (free_count != '0) begin
                    free_count     <= free_count - FREE_W'(1);
                    rsp.free_total <= free_count - FREE_W'(1);
                  end else begin
                    rsp.free_total <= free_count;
                  end
                  if (take_full) cache_valid <= 1'b0;
                end
              end
              M_FREE: begin
                if (free_hit) begin
                  rsp.granted       <= 1'b1;
                  rsp.pool_out      <= pool_q;
                  rsp.slot_out      <= slot_q;
                  rsp.status        <= STATUS_OK;
                  free_count        <= free_count + FREE_W'(1);
                  rsp.free_total    <= free_count + FREE_W'(1);
                  pool_full[pool_q] <= 1'b0;
                  if (!cache_valid) begin
                    cached_pool <= pool_q;
                    cache_valid <= 1'b1;
                  end
                end else begin
                  rsp.granted    <= 1'b0;
                  rsp.pool_out   <= '0;
                  rsp.slot_out   <= '0;
                  rsp.status     <= STATUS_BAD_FREE;
                  rsp.free_total <= free_count;
                end
              end
              M_BAD_FREE: begin
                rsp.granted    <= 1'b0;
                rsp.pool_out   <= '0;
                rsp.slot_out   <= '0;
                rsp.status     <= STATUS_BAD_FREE;
                rsp.free_total <= free_count;
              end
              default: begin
                rsp.granted    <= 1'b0;
                rsp.pool_out   <= '0;
                rsp.slot_out   <= '0;
                rsp.status     <= STATUS_EXHAUSTED;
                rsp.free_total <= free_count;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // cached pool must be active and still have room
  a_cache_usable: assert property (@(posedge clk) disable iff (rst)
    cache_valid |-> (CNT_W'(cached_pool) < active_pools) && !pool_full[cached_pool])
    else $error("cached pool inactive or full");

  a_full_only_active: assert property (@(posedge clk) disable iff (rst)
    (pool_full & ~active_mask) == '0)
    else $error("full flag on inactive pool");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_count) <= 32'(active_pools) * SLOTS)
    else $error("free count above active capacity");

  a_write_grants: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |=> rsp.valid && rsp.granted)
    else $error("bitmap write without granted beat");

endmodule

[design/bitmap_slot_allocator_top.sv]
// Bitmap slot allocator. Each request beat allocates the lowest free slot of
// the chosen pool or frees a given slot; pools are brought up in order when
// nothing is free. Requests are served one at a time: the 128-bit bitmap row
// is read from a single-port-read memory in the accept cycle and written back,
// with the result registered, once the last result is taken; a result that is
// not taken stalls the next request. The bitmap memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Top level: bitmap memory plus control, on valid/ready channels.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top import bsa_pkg::*; (
  input logic       clk,
  input logic       rst,
  bsa_req_if.sink   req,
  bsa_rsp_if.source rsp
);

  bsa_mem_req_t     mem_req;
  logic [SLOTS-1:0] rd_data;

  bsa_bitmap_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  bsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule
